// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the gravity removal block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define GRMT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
	else $error(msg);

// condition must never be seen outside reset
`define GRMT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error(msg);

`endif

// ===== hdl/grmt_pkg.sv =====
// Package: register codes, reset values and shared types of the gravity removal block.
package grmt_pkg;

	localparam int AXES       = 3;
	localparam int AXIS_W     = 2;
	localparam int MOVE_THR_W = 17;
	localparam int TRIG_THR_W = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = 1;
	localparam int QCNT_W     = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_MOVE_THR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TRIG_THR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TRIG_AXIS = 2'd2;

	localparam logic [MOVE_THR_W-1:0] MOVE_THR_RST = 17'd334;
	localparam logic [TRIG_THR_W-1:0] TRIG_THR_RST = 16'd1672;
	localparam logic TRIG_AXIS_RST = 1'b1;

	// trigger axis codes
	localparam logic AXIS_SEL_Z = 1'b0;
	localparam logic AXIS_SEL_Y = 1'b1;

	typedef struct packed {
		logic [MOVE_THR_W-1:0] move_threshold;
		logic [TRIG_THR_W-1:0] trigger_threshold;
		logic                  trigger_axis;
	} cfg_t;

endpackage

// ===== hdl/grmt_queue.sv =====
// Two-entry queue between the filter front end and the magnitude back end.
`include "assert_macros.svh"

module grmt_queue import grmt_pkg::*; #(
	parameter int W = 51
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	output logic         full,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic         empty,
	output logic [W-1:0] rdata
);

	logic [W-1:0]      mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == QCNT_W'(QDEPTH));
	assign empty   = (count_q == '0);
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				mem_q[wr_ptr_q] <= wdata;
				wr_ptr_q        <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`GRMT_NEVER(a_q_overflow, clk, arst_n, push && full, "item pushed into full queue")
	`GRMT_NEVER(a_q_count, clk, arst_n, count_q > QCNT_W'(QDEPTH), "queue count past depth")

endmodule

// ===== hdl/grmt_front.sv =====
// Front end: accepts samples, updates the per-axis gravity estimate, forms motion.
`include "assert_macros.svh"

module grmt_front import grmt_pkg::*; #(
	parameter int SAMPLE_BITS           = 16,
	parameter int GRAVITY_FRACTION_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [SAMPLE_BITS-1:0] accel_x,
	input  logic signed [SAMPLE_BITS-1:0] accel_y,
	input  logic signed [SAMPLE_BITS-1:0] accel_z,
	input  logic                          q_full,
	output logic                          q_push,
	output logic [3*(SAMPLE_BITS+1)-1:0]  q_data
);

	localparam int S     = SAMPLE_BITS;
	localparam int F     = GRAVITY_FRACTION_BITS;
	localparam int G_W   = S + F;
	localparam int OUT_W = S + 1;
	localparam int ALPHA = ((1 << F) + 5) / 10;

	typedef enum logic [1:0] {F_IDLE, F_MUL, F_ADD, F_PUSH} state_t;

	state_t            state_q;
	logic [AXIS_W-1:0] idx_q;
	logic              primed_q;
	logic [S-1:0]      acc_q  [AXES];
	logic [G_W-1:0]    grav_q [AXES];
	logic [OUT_W-1:0]  mot_q  [AXES];
	logic [G_W-1:0]    pq_s1;
	logic [F-1:0]      pr_s1;

	logic [S-1:0]         acc_c;
	logic [G_W-1:0]       g_c;
	logic [G_W-1:0]       target_c;
	logic [G_W:0]         diff_c;
	logic signed [S:0]    q_c;
	logic [F-1:0]         r_c;
	logic [F-1:0]         alpha_c;
	logic signed [G_W+1:0] prodq_c;
	logic [2*F-1:0]       prodr_c;
	logic [G_W-1:0]       gnew_c;
	logic [S-1:0]         gint_c;
	logic [OUT_W-1:0]     motion_c;
	logic                 accept;

	assign full   = (state_q != F_IDLE);
	assign accept = push && !full;
	assign q_push = (state_q == F_PUSH) && !q_full;
	assign q_data = {mot_q[2], mot_q[1], mot_q[0]};

	always_comb begin
		acc_c    = acc_q[idx_q];
		g_c      = grav_q[idx_q];
		target_c = {acc_c, {F{1'b0}}};
		diff_c   = {target_c[G_W-1], target_c} - {g_c[G_W-1], g_c};
		q_c      = $signed(diff_c[G_W:F]);
		r_c      = diff_c[F-1:0];
		alpha_c  = F'(ALPHA);
		prodq_c  = q_c * $signed({1'b0, alpha_c});
		prodr_c  = r_c * alpha_c;
		gnew_c   = primed_q ? (g_c + pq_s1 + G_W'(pr_s1)) : target_c;
		gint_c   = gnew_c[G_W-1:F];
		motion_c = {acc_c[S-1], acc_c} - {gint_c[S-1], gint_c};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IDLE;
			idx_q    <= '0;
			primed_q <= 1'b0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						acc_q[0] <= accel_x;
						acc_q[1] <= accel_y;
						acc_q[2] <= accel_z;
						idx_q    <= '0;
						state_q  <= F_MUL;
					end
				end
				F_MUL: begin
					pq_s1   <= prodq_c[G_W-1:0];
					pr_s1   <= prodr_c[2*F-1:F];
					state_q <= F_ADD;
				end
				F_ADD: begin
					grav_q[idx_q] <= gnew_c;
					mot_q[idx_q]  <= motion_c;
					if (idx_q == AXIS_W'(AXES - 1)) begin
						primed_q <= 1'b1;
						state_q  <= F_PUSH;
					end else begin
						idx_q   <= idx_q + AXIS_W'(1);
						state_q <= F_MUL;
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	`GRMT_ASSERT(a_primed_sticky, clk, arst_n, primed_q |=> primed_q, "primed flag dropped")
	`GRMT_ASSERT(a_first_zero, clk, arst_n, (state_q == F_ADD) && !primed_q |-> motion_c == '0, "first sample motion not zero")

endmodule

// ===== hdl/grmt_back.sv =====
// Back end: sums squared motion, iterative square root, flags and result register.
`include "assert_macros.svh"

module grmt_back import grmt_pkg::*; #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfg_t                          cfg,
	input  logic                          q_empty,
	output logic                          q_pop,
	input  logic [3*(SAMPLE_BITS+1)-1:0]  q_data,
	output logic                          empty,
	input  logic                          pop,
	output logic signed [SAMPLE_BITS:0]   motion_x,
	output logic signed [SAMPLE_BITS:0]   motion_y,
	output logic signed [SAMPLE_BITS:0]   motion_z,
	output logic [SAMPLE_BITS:0]          magnitude,
	output logic                          moving,
	output logic                          trigger
);

	localparam int S     = SAMPLE_BITS;
	localparam int OUT_W = S + 1;
	localparam int SQ_W  = 2 * OUT_W;
	localparam int MW    = (OUT_W > MOVE_THR_W) ? OUT_W : MOVE_THR_W;
	localparam int TW    = ((OUT_W > TRIG_THR_W) ? OUT_W : TRIG_THR_W) + 2;

	typedef enum logic [2:0] {B_IDLE, B_SQ, B_SUM, B_ROOT, B_DONE} state_t;

	state_t            state_q;
	logic [AXIS_W-1:0] idx_q;
	logic              valid_q;
	logic [OUT_W-1:0]  mot_q [AXES];
	logic [SQ_W-1:0]   sq_s1;
	logic [SQ_W-1:0]   sum_q;
	logic [SQ_W-1:0]   root_q;
	logic [SQ_W-1:0]   rbit_q;
	logic [OUT_W-1:0]  mx_q;
	logic [OUT_W-1:0]  my_q;
	logic [OUT_W-1:0]  mz_q;
	logic [OUT_W-1:0]  mag_q;
	logic              moving_q;
	logic              trigger_q;

	logic [OUT_W-1:0] sel_c;
	logic [OUT_W-1:0] abs_c;
	logic [SQ_W-1:0]  sq_c;
	logic [SQ_W-1:0]  trial_c;
	logic [OUT_W-1:0] watched_c;
	logic [TW-1:0]    tsum_c;
	logic             moving_c;
	logic             trigger_c;
	logic             root_end_c;

	assign q_pop      = (state_q == B_IDLE) && !q_empty;
	assign empty      = !valid_q;
	assign motion_x   = $signed(mx_q);
	assign motion_y   = $signed(my_q);
	assign motion_z   = $signed(mz_q);
	assign magnitude  = mag_q;
	assign moving     = moving_q;
	assign trigger    = trigger_q;
	assign root_end_c = (state_q == B_ROOT) && (rbit_q == '0);

	always_comb begin
		sel_c     = mot_q[idx_q];
		abs_c     = sel_c[OUT_W-1] ? (~sel_c + OUT_W'(1)) : sel_c;
		sq_c      = abs_c * abs_c;
		trial_c   = root_q + rbit_q;
		watched_c = (cfg.trigger_axis == AXIS_SEL_Y) ? mot_q[1] : mot_q[2];
		tsum_c    = TW'($signed(watched_c)) + TW'($signed({1'b0, cfg.trigger_threshold}));
		trigger_c = tsum_c[TW-1];
		moving_c  = MW'(root_q[OUT_W-1:0]) > MW'(cfg.move_threshold);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if ((state_q == B_DONE) && (!valid_q || pop)) begin
				valid_q <= 1'b1;
			end else if (pop && valid_q) begin
				valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						mot_q[0] <= q_data[OUT_W-1:0];
						mot_q[1] <= q_data[2*OUT_W-1:OUT_W];
						mot_q[2] <= q_data[3*OUT_W-1:2*OUT_W];
						idx_q    <= '0;
						sum_q    <= '0;
						state_q  <= B_SQ;
					end
				end
				B_SQ: begin
					sq_s1 <= sq_c;
					if (idx_q != '0) begin
						sum_q <= sum_q + sq_s1;
					end
					if (idx_q == AXIS_W'(AXES - 1)) begin
						state_q <= B_SUM;
					end else begin
						idx_q <= idx_q + AXIS_W'(1);
					end
				end
				B_SUM: begin
					sum_q   <= sum_q + sq_s1;
					root_q  <= '0;
					rbit_q  <= SQ_W'(1) << (2 * S);
					state_q <= B_ROOT;
				end
				B_ROOT: begin
					if (rbit_q == '0) begin
						state_q <= B_DONE;
					end else begin
						if (sum_q >= trial_c) begin
							sum_q  <= sum_q - trial_c;
							root_q <= (root_q >> 1) + rbit_q;
						end else begin
							root_q <= root_q >> 1;
						end
						rbit_q <= rbit_q >> 2;
					end
				end
				B_DONE: begin
					if (!valid_q || pop) begin
						mx_q      <= mot_q[0];
						my_q      <= mot_q[1];
						mz_q      <= mot_q[2];
						mag_q     <= root_q[OUT_W-1:0];
						moving_q  <= moving_c;
						trigger_q <= trigger_c;
						state_q   <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	`GRMT_ASSERT(a_root_ends, clk, arst_n, root_end_c |=> state_q == B_DONE, "root overran")

endmodule

// ===== hdl/gravity_removal_motion_trigger.sv =====
// Top level of the gravity removal and motion trigger block.
// Usage:
// Samples enter through a queue-style port: an item (accel_x/y/z) is taken at a
// clock edge with push high and full low. Results leave the same way: while
// empty is low the oldest result sits on motion_x/y/z, magnitude, moving and
// trigger, and it is taken at an edge with pop high.
// Registers are written over cfg_valid/cfg_ready (always ready) with cfg_index
// and cfg_data; write them only while no item is in flight.
// The front end runs a multiply and an add state per axis for the gravity
// update and holds full until it has pushed the item into the queue. The back
// end squares and sums the motions, then runs the one-bit-per-cycle square
// root, and pops no new item until its result is stored; it sets the sustained rate.
// A two-entry queue sits between the halves and a result register at the
// output; a stalled receiver leaves one item in the result register, one in
// the back end, two in the queue and one in the front end, which holds full.
// Reset clears the registers to their defaults and the gravity estimate is
// reloaded from the first sample, whose motions and magnitude are zero.
module gravity_removal_motion_trigger import grmt_pkg::*; #(
	parameter int SAMPLE_BITS           = 16,
	parameter int GRAVITY_FRACTION_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [SAMPLE_BITS-1:0] accel_x,
	input  logic signed [SAMPLE_BITS-1:0] accel_y,
	input  logic signed [SAMPLE_BITS-1:0] accel_z,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	output logic                          empty,
	input  logic                          pop,
	output logic signed [SAMPLE_BITS:0]   motion_x,
	output logic signed [SAMPLE_BITS:0]   motion_y,
	output logic signed [SAMPLE_BITS:0]   motion_z,
	output logic [SAMPLE_BITS:0]          magnitude,
	output logic                          moving,
	output logic                          trigger
);

	localparam int QW = 3 * (SAMPLE_BITS + 1);

	cfg_t          cfg_q;
	logic          fq_push;
	logic          fq_full;
	logic [QW-1:0] fq_wdata;
	logic          bq_pop;
	logic          bq_empty;
	logic [QW-1:0] bq_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.move_threshold    <= MOVE_THR_RST;
			cfg_q.trigger_threshold <= TRIG_THR_RST;
			cfg_q.trigger_axis      <= TRIG_AXIS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MOVE_THR:  cfg_q.move_threshold    <= cfg_data[MOVE_THR_W-1:0];
				CFG_TRIG_THR:  cfg_q.trigger_threshold <= cfg_data[TRIG_THR_W-1:0];
				CFG_TRIG_AXIS: cfg_q.trigger_axis      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	grmt_front #(
		.SAMPLE_BITS           (SAMPLE_BITS),
		.GRAVITY_FRACTION_BITS (GRAVITY_FRACTION_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.accel_x (accel_x),
		.accel_y (accel_y),
		.accel_z (accel_z),
		.q_full  (fq_full),
		.q_push  (fq_push),
		.q_data  (fq_wdata)
	);

	grmt_queue #(
		.W (QW)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fq_push),
		.full   (fq_full),
		.wdata  (fq_wdata),
		.pop    (bq_pop),
		.empty  (bq_empty),
		.rdata  (bq_rdata)
	);

	grmt_back #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (bq_empty),
		.q_pop     (bq_pop),
		.q_data    (bq_rdata),
		.empty     (empty),
		.pop       (pop),
		.motion_x  (motion_x),
		.motion_y  (motion_y),
		.motion_z  (motion_z),
		.magnitude (magnitude),
		.moving    (moving),
		.trigger   (trigger)
	);

endmodule
